>>> hdl/table_linear_and_binary_search_top_assert.svh
// Assertion macros for the table search block.
// Used by the port-level checker; depends on nothing else.
`ifndef TABLE_LINEAR_AND_BINARY_SEARCH_TOP_ASSERT_SVH
`define TABLE_LINEAR_AND_BINARY_SEARCH_TOP_ASSERT_SVH

// Concurrent assertion that is off while reset is high.
`define TBS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that also holds across reset.
`define TBS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/tbs_pkg.sv
// Shared types and constants for the table search block.
// No dependencies; used by the controller, datapath, top level and checker.
package tbs_pkg;

   // Fixed field widths of the request and response
   localparam int POS_WIDTH     = 11;
   localparam int OPERAND_WIDTH = 32;

   // Request action codes
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_LINEAR = 2'd1;
   localparam logic [1:0] ACT_BINARY = 2'd2;

   typedef struct packed {
      logic [1:0]                      action;
      logic [POS_WIDTH-1:0]            slot;
      logic signed [OPERAND_WIDTH-1:0] operand;
   } req_type;

   typedef struct packed {
      logic [POS_WIDTH-1:0] position;
      logic                 found;
   } rsp_type;

   // Datapath commands issued by the controller, one per cycle
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_LIN_START,
      CMD_LIN_STEP,
      CMD_BIN_START,
      CMD_BIN_FIRST,
      CMD_BIN_LAST,
      CMD_BIN_PROBE,
      CMD_BIN_NARROW,
      CMD_HIT,
      CMD_MISS
   } dp_cmd_type;

   // Datapath status seen by the controller
   typedef struct packed {
      logic count_zero;  // table in use is empty
      logic match;       // registered read data equals key
      logic lin_last;    // linear compare is at the last slot in use
      logic bin_empty;   // binary interval lo > hi
   } dp_status_type;

endpackage

>>> hdl/tbs_datapath.sv
// Datapath of the table search block: table memory, key, bounds, result register.
// Depends on tbs_pkg; driven by commands from tbs_controller.
module tbs_datapath #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tbs_pkg::req_type               req_payload,
   input  logic                           csr_wr_en,
   input  logic [tbs_pkg::POS_WIDTH-1:0]  csr_wr_data,
   input  tbs_pkg::dp_cmd_type            cmd,
   output tbs_pkg::dp_status_type         status,
   output tbs_pkg::rsp_type               rsp_payload
);

   localparam int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW         = tbs_pkg::POS_WIDTH;
   localparam int IW         = PW + 1;
   localparam logic [31:0] DEPTH_W = 32'(DEPTH);
   localparam logic [DATA_WIDTH-1:0] SIGN_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [DATA_WIDTH-1:0] first_ff, first_in;
   logic [DATA_WIDTH-1:0] req_key;
   logic [PW-1:0]         count_ff;
   logic [PW-1:0]         used_ff, used_in, used_now;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [IW-1:0]         lo_ff, lo_in, hi_ff, hi_in, mid;
   logic                  asc_ff, asc_in;
   tbs_pkg::rsp_type      rsp_ff, rsp_in;
   logic [ADDR_WIDTH-1:0] rd_addr, wr_addr;
   logic                  wr_en, slot_ok;

   // Slot number (1-based) to memory address
   function automatic logic [ADDR_WIDTH-1:0] to_addr(input logic [IW-1:0] p);
      logic [31:0] w;
      w = 32'(p) - 32'd1;
      return w[ADDR_WIDTH-1:0];
   endfunction

   // Sign-flipped key so unsigned compare gives signed order
   assign req_key  = DATA_WIDTH'($unsigned(req_payload.operand)) ^ SIGN_BIT;
   assign used_now = (32'(count_ff) > DEPTH_W) ? PW'(DEPTH) : count_ff;
   assign slot_ok  = (req_payload.slot != '0) && (32'(req_payload.slot) <= DEPTH_W);
   assign wr_addr  = to_addr({1'b0, req_payload.slot});
   assign mid      = (lo_ff + hi_ff) >> 1;

   // Command decode
   always_comb begin
      key_in   = key_ff;
      used_in  = used_ff;
      pos_in   = pos_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      first_in = first_ff;
      asc_in   = asc_ff;
      rsp_in   = rsp_ff;
      rd_addr  = '0;
      wr_en    = 1'b0;
      unique case (cmd)
         tbs_pkg::CMD_LOAD: begin
            wr_en = slot_ok;
         end
         tbs_pkg::CMD_LIN_START: begin
            key_in  = req_key;
            used_in = used_now;
            pos_in  = PW'(1);
         end
         tbs_pkg::CMD_LIN_STEP: begin
            rd_addr = to_addr({1'b0, pos_ff} + IW'(1));
            pos_in  = pos_ff + PW'(1);
         end
         tbs_pkg::CMD_BIN_START: begin
            key_in  = req_key;
            used_in = used_now;
            lo_in   = IW'(1);
            hi_in   = {1'b0, used_now};
         end
         tbs_pkg::CMD_BIN_FIRST: begin
            first_in = rdata_ff;
            rd_addr  = to_addr(hi_ff);
         end
         tbs_pkg::CMD_BIN_LAST: begin
            asc_in = rdata_ff >= first_ff;
         end
         tbs_pkg::CMD_BIN_PROBE: begin
            rd_addr = to_addr(mid);
            pos_in  = mid[PW-1:0];
         end
         tbs_pkg::CMD_BIN_NARROW: begin
            if ((rdata_ff > key_ff) == asc_ff) begin
               hi_in = {1'b0, pos_ff} - IW'(1);
            end else begin
               lo_in = {1'b0, pos_ff} + IW'(1);
            end
         end
         tbs_pkg::CMD_HIT: begin
            rsp_in.position = pos_ff;
            rsp_in.found    = 1'b1;
         end
         tbs_pkg::CMD_MISS: begin
            rsp_in.position = '0;
            rsp_in.found    = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // Table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_key;
      end
      rdata_ff <= mem[rd_addr];
   end

   // Count register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Search working registers
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      used_ff  <= used_in;
      pos_ff   <= pos_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      first_ff <= first_in;
      asc_ff   <= asc_in;
      rsp_ff   <= rsp_in;
   end

   assign status.count_zero = (used_now == '0);
   assign status.match      = (rdata_ff == key_ff);
   assign status.lin_last   = (pos_ff == used_ff);
   assign status.bin_empty  = (lo_ff > hi_ff);
   assign rsp_payload       = rsp_ff;

endmodule

>>> hdl/tbs_controller.sv
// Controller of the table search block: sequences loads, linear and binary search.
// Depends on tbs_pkg; drives tbs_datapath through its command port.
module tbs_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             action,
   input  tbs_pkg::dp_status_type status,
   output tbs_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIN_RUN,
      ST_BIN_FIRST,
      ST_BIN_LAST,
      ST_BIN_PROBE,
      ST_BIN_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   // Next state and command
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = tbs_pkg::CMD_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (action)
                  tbs_pkg::ACT_LOAD: begin
                     cmd = tbs_pkg::CMD_LOAD;
                  end
                  tbs_pkg::ACT_LINEAR: begin
                     if (status.count_zero) begin
                        cmd       = tbs_pkg::CMD_MISS;
                        strobe_in = 1'b1;
                     end else begin
                        cmd      = tbs_pkg::CMD_LIN_START;
                        state_in = ST_LIN_RUN;
                     end
                  end
                  tbs_pkg::ACT_BINARY: begin
                     if (status.count_zero) begin
                        cmd       = tbs_pkg::CMD_MISS;
                        strobe_in = 1'b1;
                     end else begin
                        cmd      = tbs_pkg::CMD_BIN_START;
                        state_in = ST_BIN_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // One compare per cycle, next read issued alongside
         ST_LIN_RUN: begin
            if (status.match) begin
               cmd       = tbs_pkg::CMD_HIT;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (status.lin_last) begin
               cmd       = tbs_pkg::CMD_MISS;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd = tbs_pkg::CMD_LIN_STEP;
            end
         end
         ST_BIN_FIRST: begin
            cmd      = tbs_pkg::CMD_BIN_FIRST;
            state_in = ST_BIN_LAST;
         end
         ST_BIN_LAST: begin
            cmd      = tbs_pkg::CMD_BIN_LAST;
            state_in = ST_BIN_PROBE;
         end
         ST_BIN_PROBE: begin
            if (status.bin_empty) begin
               cmd       = tbs_pkg::CMD_MISS;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd      = tbs_pkg::CMD_BIN_PROBE;
               state_in = ST_BIN_CHECK;
            end
         end
         ST_BIN_CHECK: begin
            if (status.match) begin
               cmd       = tbs_pkg::CMD_HIT;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cmd      = tbs_pkg::CMD_BIN_NARROW;
               state_in = ST_BIN_PROBE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

>>> hdl/table_linear_and_binary_search_top.sv
// Top level of the table search block: a table of signed entries with linear and
// binary search. Depends on tbs_pkg, tbs_controller and tbs_datapath.
//
// Usage:
//  - Request: drive req_payload and raise start; the transfer happens at an edge
//    where start is high and busy is low. Action load writes one slot (1..DEPTH);
//    other slots are ignored. Action linear or binary searches slots 1..count.
//  - Response: one per search, on rsp_payload for exactly one cycle with rsp_strobe
//    high; found is set and position holds the slot on a match, else both are 0.
//    The receiver cannot stall; take each response when it is strobed.
//  - Count: csr_wr_en with csr_wr_data sets the slots in use; write only while
//    idle. Counts above DEPTH act as DEPTH.
// Sequencing, all set by the single registered read port of the table memory:
//  - Load: busy stays low, so loads can follow back to back.
//  - Empty table: response strobed the cycle after the request.
//  - Linear: compares slots from 1 upward; a match or the last slot in use ends
//    the search with its response.
//  - Binary: reads the end entries to find the order, then probes midpoints until a
//    match or an empty interval. A search holds busy until its response is strobed.
// Reset clears the count and the controller; table contents are undefined until loaded.
module table_linear_and_binary_search_top #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  tbs_pkg::req_type              req_payload,
   output logic                          rsp_strobe,
   output tbs_pkg::rsp_type              rsp_payload,
   input  logic                          csr_wr_en,
   input  logic [tbs_pkg::POS_WIDTH-1:0] csr_wr_data
);

   tbs_pkg::dp_cmd_type    cmd;
   tbs_pkg::dp_status_type status;

   tbs_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_payload.action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   tbs_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> hdl/tbs_checker.sv
// Port-level checker for the table search block, bound to the top level.
// Depends on tbs_pkg and table_linear_and_binary_search_top_assert.svh.
`include "table_linear_and_binary_search_top_assert.svh"

module tbs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input tbs_pkg::req_type              req_payload,
   input logic                          rsp_strobe,
   input tbs_pkg::rsp_type              rsp_payload,
   input logic                          csr_wr_en,
   input logic [tbs_pkg::POS_WIDTH-1:0] csr_wr_data
);

   logic load_xfer;
   logic cfg_seen;

   assign load_xfer = start && !busy && (req_payload.action == tbs_pkg::ACT_LOAD);
   // Config port is observed only; writes carry no handshake to check
   assign cfg_seen  = csr_wr_en && (csr_wr_data == csr_wr_data);

   // Found flag agrees with a nonzero position
   `TBS_ASSERT(a_found_pos, clock, reset, rsp_strobe |-> (rsp_payload.found == (rsp_payload.position != '0)), "found and position disagree")

   // A response only follows a busy cycle or a request transfer
   `TBS_ASSERT(a_rsp_cause, clock, reset, rsp_strobe |-> $past(busy || start), "response without a request")

   // A load with no count write alongside never starts a search or gives a response
   `TBS_ASSERT(a_load_quiet, clock, reset, load_xfer && !cfg_seen |=> !busy && !rsp_strobe, "load caused busy or response")

   // Reset leaves the block idle with no response
   `TBS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy && !rsp_strobe, "not idle after reset")

endmodule

bind table_linear_and_binary_search_top tbs_checker u_tbs_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
// Testbench for table_linear_and_binary_search_top: loads tables of signed entries and checks
// every linear and binary search answer. Depends on tbs_pkg and the top level RTL only.

module tb;

   localparam int          TABLE_DEPTH    = 1024;
   localparam int          SLOT_CEILING   = 2047;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          TAIL_CYCLES    = 1100;
   localparam int          WATCHDOG_LIMIT = 6000;
   localparam logic [1:0]  ACT_UNUSED     = 2'd3;
   localparam longint      WORD_FLOOR     = -64'sd2147483648;
   localparam longint      WORD_SPAN      = 64'sd4294967295;
   localparam logic signed [31:0] INT_LOW  = 32'sh8000_0000;
   localparam logic signed [31:0] INT_HIGH = 32'sh7fff_ffff;

   // Tracks the table contents and the slots in use as the block sees them, and holds the
   // search answers that are still to come back.
   class table_search_board;
      logic signed [31:0] entries [1:TABLE_DEPTH];
      int                 used_slots;
      tbs_pkg::rsp_type   answers [$];
      int                 failures;

      function new();
         used_slots = 0;
         failures   = 0;
         for (int i = 1; i <= TABLE_DEPTH; i++) entries[i] = '0;
      endfunction

      // Counts above the table depth act as the full depth
      function void set_count(logic [tbs_pkg::POS_WIDTH-1:0] count);
         used_slots = (count > TABLE_DEPTH) ? TABLE_DEPTH : int'(count);
      endfunction

      function int scan_linear(logic signed [31:0] key);
         for (int i = 1; i <= used_slots; i++) begin
            if (entries[i] == key) return i;
         end
         return 0;
      endfunction

      // Order is taken from the end entries; first probed match wins
      function int scan_binary(logic signed [31:0] key);
         int lo;
         int hi;
         int mid;
         bit ascending;
         lo = 1;
         hi = used_slots;
         if (hi < 1) return 0;
         ascending = entries[hi] >= entries[1];
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (entries[mid] == key) return mid;
            if ((entries[mid] > key) == ascending) hi = mid - 1;
            else lo = mid + 1;
         end
         return 0;
      endfunction

      // Called for every accepted request transfer, in order
      function void note_transfer(tbs_pkg::req_type item);
         logic signed [31:0] key;
         int                 hit;
         tbs_pkg::rsp_type   want;
         key = item.operand;
         case (item.action)
            tbs_pkg::ACT_LOAD: begin
               if (item.slot >= 1 && item.slot <= TABLE_DEPTH) entries[item.slot] = key;
               return;
            end
            tbs_pkg::ACT_LINEAR: hit = scan_linear(key);
            tbs_pkg::ACT_BINARY: hit = scan_binary(key);
            default: return;
         endcase
         want.position = hit[tbs_pkg::POS_WIDTH-1:0];
         want.found    = (hit != 0);
         answers.push_back(want);
      endfunction

      function void check_result(tbs_pkg::rsp_type got);
         tbs_pkg::rsp_type want;
         if (answers.size() == 0) begin
            $error("search result with none outstanding: position %0d found %0b",
                   got.position, got.found);
            failures++;
            return;
         end
         want = answers.pop_front();
         if (got.position !== want.position) begin
            $error("position mismatch: expected %0d, actual %0d", want.position, got.position);
            failures++;
         end
         if (got.found !== want.found) begin
            $error("found mismatch: expected %0b, actual %0b", want.found, got.found);
            failures++;
         end
      endfunction

      function int pending();
         return answers.size();
      endfunction
   endclass

   typedef enum {FILL_RISING, FILL_FALLING, FILL_FLAT, FILL_NOISE} fill_shape_type;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          start       = 1'b0;
   logic                          busy;
   tbs_pkg::req_type              req_payload = '0;
   logic                          rsp_strobe;
   tbs_pkg::rsp_type              rsp_payload;
   logic                          csr_wr_en   = 1'b0;
   logic [tbs_pkg::POS_WIDTH-1:0] csr_wr_data = '0;

   table_search_board board = new();

   // Stimulus-side copy of the table, used to pick keys that hit
   logic signed [31:0] shadow [1:TABLE_DEPTH];
   bit                 burst_mode = 1'b0;
   int                 quiet_cycles = 0;

   table_linear_and_binary_search_top #(
      .DEPTH      (TABLE_DEPTH),
      .DATA_WIDTH (32)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor: results first, then the request transfer of this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) board.check_result(rsp_payload);
         if (start && !busy) board.note_transfer(req_payload);
      end
   end

   // Watchdog on cycles with no transfer either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("table_linear_and_binary_search_top test failed");
            $finish;
         end
      end
   end

   // Mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (burst_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one request and hold it until the transfer
   task automatic send_item(tbs_pkg::req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= item;
      start       <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic load_slot(int slot_no, logic signed [31:0] value);
      tbs_pkg::req_type item;
      item.action  = tbs_pkg::ACT_LOAD;
      item.slot    = slot_no[tbs_pkg::POS_WIDTH-1:0];
      item.operand = value;
      if (slot_no >= 1 && slot_no <= TABLE_DEPTH) shadow[slot_no] = value;
      send_item(item);
   endtask

   // Slot field is don't-care for searches, so it gets noise
   task automatic search_for(logic [1:0] action, logic signed [31:0] key);
      tbs_pkg::req_type item;
      item.action  = action;
      item.slot    = tbs_pkg::POS_WIDTH'($urandom_range(0, SLOT_CEILING));
      item.operand = key;
      send_item(item);
   endtask

   task automatic send_unused();
      tbs_pkg::req_type item;
      item.action  = ACT_UNUSED;
      item.slot    = tbs_pkg::POS_WIDTH'($urandom_range(0, SLOT_CEILING));
      item.operand = $urandom;
      send_item(item);
   endtask

   // Stop sending and wait until every search answer is back and the block is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0 || busy) @(posedge clock);
   endtask

   task automatic write_entry_count(logic [tbs_pkg::POS_WIDTH-1:0] count);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_data <= count;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.set_count(count);
   endtask

   // Load slots 1..used with sorted (either way), flat or noisy content
   task automatic fill_table(int used);
      fill_shape_type     shape;
      longint             stride_max;
      longint             span;
      longint             level;
      logic signed [31:0] flat_value;
      logic signed [31:0] value;
      int                 roll;
      int                 slot_no;
      roll  = $urandom_range(0, 99);
      shape = (roll < 40) ? FILL_RISING : (roll < 80) ? FILL_FALLING :
              (roll < 90) ? FILL_FLAT : FILL_NOISE;
      if ($urandom_range(0, 1) == 0) stride_max = longint'($urandom_range(1, 3));
      else stride_max = WORD_SPAN / (used + 1);
      span  = WORD_SPAN - longint'(used) * stride_max;
      level = WORD_FLOOR;
      if ($urandom_range(0, 3) != 0)
         level = WORD_FLOOR + longint'($urandom_range(0, 32'(span)));
      flat_value = $urandom;
      for (int i = 1; i <= used; i++) begin
         level   = level + longint'($urandom_range(0, 32'(stride_max)));
         slot_no = (shape == FILL_FALLING) ? used + 1 - i : i;
         case (shape)
            FILL_FLAT:  value = flat_value;
            FILL_NOISE: value = $urandom;
            default:    value = level[31:0];
         endcase
         load_slot(slot_no, value);
      end
   endtask

   // Mostly searches for present keys, with loads and ignored actions as noise
   task automatic random_phase(int used, int count);
      int                 roll;
      int                 slot_no;
      logic signed [31:0] key;
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(0, 99);
         if (roll < 84) begin
            key = $urandom;
            if (used > 0 && $urandom_range(0, 9) < 8) begin
               key = shadow[$urandom_range(1, used)];
               if ($urandom_range(0, 7) == 0) key = key + 1;
            end
            search_for((roll < 42) ? tbs_pkg::ACT_LINEAR : tbs_pkg::ACT_BINARY, key);
         end else if (roll < 96) begin
            roll = $urandom_range(0, 99);
            if (roll < 40 && used > 0) slot_no = $urandom_range(1, used);
            else if (roll < 70 && used < TABLE_DEPTH)
               slot_no = $urandom_range(used + 1, TABLE_DEPTH);
            else if (roll < 85) slot_no = 0;
            else slot_no = $urandom_range(TABLE_DEPTH + 1, SLOT_CEILING);
            // rewriting a slot with its own value keeps the order intact
            if (slot_no >= 1 && slot_no <= used && $urandom_range(0, 1) == 0)
               load_slot(slot_no, shadow[slot_no]);
            else
               load_slot(slot_no, $urandom);
         end else begin
            send_unused();
         end
      end
   endtask

   initial begin
      int count;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Empty table straight out of reset, ignored actions and out-of-range loads
      search_for(tbs_pkg::ACT_LINEAR, 0);
      search_for(tbs_pkg::ACT_BINARY, INT_LOW);
      send_unused();
      load_slot(0, 7);
      load_slot(SLOT_CEILING, -1);
      load_slot(TABLE_DEPTH + 1, 7);
      load_slot(1, INT_LOW);
      load_slot(2, INT_HIGH);
      search_for(tbs_pkg::ACT_LINEAR, INT_LOW);

      // Two extreme entries, then a duplicate of the first at the end
      write_entry_count(2);
      search_for(tbs_pkg::ACT_LINEAR, INT_LOW);
      search_for(tbs_pkg::ACT_LINEAR, INT_HIGH);
      search_for(tbs_pkg::ACT_BINARY, INT_HIGH);
      search_for(tbs_pkg::ACT_BINARY, INT_LOW);
      search_for(tbs_pkg::ACT_BINARY, 0);
      search_for(tbs_pkg::ACT_LINEAR, 7);
      load_slot(3, INT_LOW);
      write_entry_count(3);
      search_for(tbs_pkg::ACT_LINEAR, INT_LOW);
      search_for(tbs_pkg::ACT_BINARY, INT_LOW);
      search_for(tbs_pkg::ACT_BINARY, INT_HIGH);
      load_slot(TABLE_DEPTH, INT_HIGH);

      // Small tables carry the random traffic
      for (int p = 0; p < 12; p++) begin
         count      = (p == 0) ? 1 : (p == 1) ? 0 : $urandom_range(2, 48);
         burst_mode = (p % 4 == 3);
         write_entry_count(tbs_pkg::POS_WIDTH'(count));
         fill_table(count);
         random_phase(count, 25);
      end

      burst_mode = 1'b0;
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("table_linear_and_binary_search_top test passed");
      end else begin
         $display("table_linear_and_binary_search_top test failed");
      end
      $finish;
   end
endmodule
